>>> sv/bmprgb_pkg.sv
// Shared types and constants of the BMP to RGB555 pixel writer.
`default_nettype none

package bmprgb_pkg;

   // Byte counter saturates here: any position at or past 2^16 behaves the same.
   localparam int unsigned IDX_W = 17;

   // Header byte positions (little-endian fields).
   localparam logic [IDX_W-1:0] IDX_SIZE_B0   = 17'd2;
   localparam logic [IDX_W-1:0] IDX_SIZE_B1   = 17'd3;
   localparam logic [IDX_W-1:0] IDX_SIZE_B2   = 17'd4;
   localparam logic [IDX_W-1:0] IDX_SIZE_B3   = 17'd5;
   localparam logic [IDX_W-1:0] IDX_OFFSET_B0 = 17'd10;
   localparam logic [IDX_W-1:0] IDX_OFFSET_B1 = 17'd11;
   localparam logic [IDX_W-1:0] IDX_WIDTH_B0  = 17'd18;
   localparam logic [IDX_W-1:0] IDX_WIDTH_B1  = 17'd19;
   localparam logic [IDX_W-1:0] IDX_HEIGHT_B0 = 17'd22;
   localparam logic [IDX_W-1:0] IDX_HEIGHT_B1 = 17'd23;
   localparam logic [IDX_W-1:0] IDX_DATA_MIN  = 17'd24;

   // Configuration register indexes.
   localparam logic CSR_ORIGIN_X = 1'b0;
   localparam logic CSR_ORIGIN_Y = 1'b1;

   // Position of a byte within a B,G,R triple.
   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_RED   = 2'd2;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [14:0] pixel_color;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> sv/bmprgb_div.sv
// Iterative restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
`default_nettype none

module bmprgb_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic [31:0]      quotient
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] rem_sh;
   logic [16:0] diff;
   logic        ge;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      rem_sh   = {rem_ff, quo_ff[31]};
      diff     = rem_sh - {1'b0, dsr_ff};
      ge       = (rem_sh >= {1'b0, dsr_ff});
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               count_in = '0;
               rem_in   = '0;
               quo_in   = dividend;
               dsr_in   = divisor;
            end
         end
         ST_RUN: begin
            // shift in the next dividend bit, subtract when it fits
            rem_in   = ge ? diff[15:0] : rem_sh[15:0];
            quo_in   = {quo_ff[30:0], ge};
            count_in = count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         quo_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         quo_ff   <= quo_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = (state_ff == ST_RUN);
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> sv/bmp24_to_rgb555_pixel_writer.sv
// Top level: streaming 24-bit BMP parser that emits RGB555 pixel writes.
//
// Usage: feed the BMP file one byte per item on the req_ channel, marking the
// final byte with last_byte. Header fields (size, data offset, width, height)
// are captured as they pass. Pixel bytes are grouped as B,G,R triples and each
// triple whose column is below the clip limit produces one rsp_ item with
// screen coordinates and a 15-bit RGB555 color.
// Throughput: one byte per cycle while req_stall is low; the byte at header
// position 23 starts the clip-limit division unless the image is degenerate or
// it is the last byte, and intake stays stalled while the divider runs.
// A pixel item is presented on rsp_ the cycle after its red byte unless older
// items are queued ahead of it. A two-entry output queue decouples the sides;
// a stalled receiver only throttles intake once both entries are full.
// Reset clears the parser, the queue and the origin registers; last_byte
// re-arms the parser after its own byte is handled, keeping the origin.
// csr_ writes set origin_x (index 0) and origin_y (index 1); write only idle.
`default_nettype none

module bmp24_to_rgb555_pixel_writer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire bmprgb_pkg::req_item_type  req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output bmprgb_pkg::rsp_item_type       rsp_payload,
   input  wire logic                      csr_write,
   input  wire logic                      csr_index,
   input  wire logic [9:0]                csr_data
);

   localparam int unsigned IW = bmprgb_pkg::IDX_W;

   // configuration
   logic [9:0] origin_x_ff, origin_y_ff;

   // parser state
   logic [IW-1:0] byte_index_ff,   byte_index_in;
   logic [31:0]   file_size_ff,    file_size_in;
   logic [15:0]   data_offset_ff,  data_offset_in;
   logic [15:0]   image_width_ff,  image_width_in;
   logic [15:0]   image_height_ff, image_height_in;
   logic [15:0]   column_count_ff, column_count_in;
   logic [15:0]   row_count_ff,    row_count_in;
   logic [7:0]    held_blue_ff,    held_blue_in;
   logic [7:0]    held_green_ff,   held_green_in;
   logic [1:0]    byte_phase_ff,   byte_phase_in;
   logic          image_done_ff,   image_done_in;

   // output queue: entry 0 is the head
   bmprgb_pkg::rsp_item_type q_ff [2];
   bmprgb_pkg::rsp_item_type q_in [2];
   logic [1:0] q_count_ff, q_count_in;

   // divider interface; the quotient register holds the column limit
   logic        div_start;
   logic        div_busy;
   logic [31:0] column_limit;
   logic [31:0] div_dividend;

   logic                     accept;
   logic                     pop;
   logic                     push;
   logic                     last;
   logic [7:0]               b;
   logic [15:0]              height_full;
   logic                     pixel_active;
   logic                     col_next_wrap;
   logic [15:0]              col_next;
   bmprgb_pkg::rsp_item_type pixel;

   bmprgb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (height_full),
      .busy     (div_busy),
      .quotient (column_limit)
   );

   // hold intake while dividing or while the queue is full
   assign req_stall = div_busy || (q_count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (q_count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_payload = q_ff[0];

   assign b            = req_payload.file_byte;
   assign last         = req_payload.last_byte;
   assign height_full  = {b, image_height_ff[7:0]};
   assign div_dividend = file_size_ff - {16'd0, data_offset_ff};

   assign pixel_active = (byte_index_ff >= bmprgb_pkg::IDX_DATA_MIN)
                      && (byte_index_ff >= {1'b0, data_offset_ff})
                      && !image_done_ff;

   assign col_next      = column_count_ff + 16'd1;
   assign col_next_wrap = (col_next >= image_width_ff);

   assign pixel.pixel_x     = {6'd0, origin_x_ff} + column_count_ff;
   assign pixel.pixel_y     = {6'd0, origin_y_ff} + image_height_ff - 16'd1 - row_count_ff;
   assign pixel.pixel_color = {b[7:3], held_green_ff[7:3], held_blue_ff[7:3]};

   always_comb begin
      byte_index_in   = byte_index_ff;
      file_size_in    = file_size_ff;
      data_offset_in  = data_offset_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      held_blue_in    = held_blue_ff;
      held_green_in   = held_green_ff;
      byte_phase_in   = byte_phase_ff;
      image_done_in   = image_done_ff;
      div_start       = 1'b0;
      push            = 1'b0;

      if (accept) begin
         // capture header fields
         case (byte_index_ff)
            bmprgb_pkg::IDX_SIZE_B0:   file_size_in[7:0]      = b;
            bmprgb_pkg::IDX_SIZE_B1:   file_size_in[15:8]     = b;
            bmprgb_pkg::IDX_SIZE_B2:   file_size_in[23:16]    = b;
            bmprgb_pkg::IDX_SIZE_B3:   file_size_in[31:24]    = b;
            bmprgb_pkg::IDX_OFFSET_B0: data_offset_in[7:0]    = b;
            bmprgb_pkg::IDX_OFFSET_B1: data_offset_in[15:8]   = b;
            bmprgb_pkg::IDX_WIDTH_B0:  image_width_in[7:0]    = b;
            bmprgb_pkg::IDX_WIDTH_B1:  image_width_in[15:8]   = b;
            bmprgb_pkg::IDX_HEIGHT_B0: image_height_in[7:0]   = b;
            bmprgb_pkg::IDX_HEIGHT_B1: begin
               image_height_in[15:8] = b;
               // degenerate image: no pixels for this file
               if (height_full == 16'd0 || image_width_ff == 16'd0
                   || data_offset_ff < 16'd24) begin
                  image_done_in = 1'b1;
               end else begin
                  div_start = !last;
               end
            end
            default: begin
            end
         endcase

         // group pixel bytes into B,G,R triples
         if (pixel_active) begin
            case (byte_phase_ff)
               bmprgb_pkg::PHASE_BLUE: begin
                  held_blue_in  = b;
                  byte_phase_in = bmprgb_pkg::PHASE_GREEN;
               end
               bmprgb_pkg::PHASE_GREEN: begin
                  held_green_in = b;
                  byte_phase_in = bmprgb_pkg::PHASE_RED;
               end
               default: begin
                  push          = ({16'd0, column_count_ff} < column_limit);
                  byte_phase_in = bmprgb_pkg::PHASE_BLUE;
                  if (col_next_wrap) begin
                     column_count_in = '0;
                     row_count_in    = row_count_ff + 16'd1;
                     if ((row_count_ff + 16'd1) >= image_height_ff) begin
                        image_done_in = 1'b1;
                     end
                  end else begin
                     column_count_in = col_next;
                  end
               end
            endcase
         end

         // saturate rather than wrap back into the header
         if (byte_index_ff != '1) begin
            byte_index_in = byte_index_ff + 1'b1;
         end

         // re-arm after the final byte
         if (last) begin
            byte_index_in   = '0;
            file_size_in    = '0;
            data_offset_in  = '0;
            image_width_in  = '0;
            image_height_in = '0;
            column_count_in = '0;
            row_count_in    = '0;
            held_blue_in    = '0;
            held_green_in   = '0;
            byte_phase_in   = bmprgb_pkg::PHASE_BLUE;
            image_done_in   = 1'b0;
         end
      end
   end

   // output queue update
   always_comb begin
      q_in[0]    = q_ff[0];
      q_in[1]    = q_ff[1];
      q_count_in = q_count_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (pop) begin
            if (q_count_ff == 2'd1) begin
               q_in[0] = pixel;
            end else begin
               q_in[1] = pixel;
            end
         end else if (q_count_ff == 2'd0) begin
            q_in[0] = pixel;
         end else begin
            q_in[1] = pixel;
         end
      end
      q_count_in = q_count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         byte_index_ff   <= '0;
         file_size_ff    <= '0;
         data_offset_ff  <= '0;
         image_width_ff  <= '0;
         image_height_ff <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         held_blue_ff    <= '0;
         held_green_ff   <= '0;
         byte_phase_ff   <= bmprgb_pkg::PHASE_BLUE;
         image_done_ff   <= 1'b0;
         q_count_ff      <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               bmprgb_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_data;
               bmprgb_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_data;
               default: begin
               end
            endcase
         end
         byte_index_ff   <= byte_index_in;
         file_size_ff    <= file_size_in;
         data_offset_ff  <= data_offset_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         held_blue_ff    <= held_blue_in;
         held_green_ff   <= held_green_in;
         byte_phase_ff   <= byte_phase_in;
         image_done_ff   <= image_done_in;
         q_count_ff      <= q_count_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

endmodule

`default_nettype wire
